@@ src/prq_pkg.sv @@
package prq_pkg;

  localparam int unsigned PidW  = 10;
  localparam int unsigned PrioW = 8;
  localparam int unsigned InW   = 24;
  localparam int unsigned OutW  = 24;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_POP    = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef struct packed {
    logic [PidW-1:0]  pid;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Command broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic    match_en;
    logic    apply_en;
    action_e op;
    entry_t  key;
  } cell_ctrl_t;

endpackage

@@ src/priority_ready_queue.sv @@
// Ordered ready queue of up to DEPTH (process id, priority) entries.
// Input channel s_axis: one word per operation, carrying the action, the
// process id and the priority. Output channel m_axis: exactly one result
// word per operation, in order, reporting the removed entry, whether one
// was found, whether the queue is now empty and whether an insert or append
// was refused because the queue was full.
// The entries live in a row of cells, front at cell 0. Each operation passes
// through the accept, match and apply steps: in the match step every cell
// compares its entry with the key in parallel, and in the apply step the
// first-hit chain runs through the row and every cell loads its own, its left
// or its right neighbor's entry. A new word is accepted only in idle, once the
// last one is through; the result is registered for m_axis after the apply step.
// The output register decouples the sides: while a result waits for
// m_axis_tready the next word is still accepted and processed, and only a
// second finished result then holds the sequencer until the first drains.
// Reset empties the queue at once; cell contents need no clearing because
// only occupied cells are ever read.
module priority_ready_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] action, [11:2] pid, [19:12] priority_req, [23:20] zero
  input  logic [prq_pkg::InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] found, [10:1] out_pid, [18:11] out_priority, [19] empty_res,
  // [20] dropped, [23:21] zero
  output logic [prq_pkg::OutW-1:0] m_axis_tdata
);
  import prq_pkg::*;

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             dropped;
    logic             empty_res;
    logic [PrioW-1:0] out_priority;
    logic [PidW-1:0]  out_pid;
    logic             found;
  } result_t;

  state_e           state_q, state_d;
  action_e          op_q;
  entry_t           key_q;
  logic [OccW-1:0]  occ_q, occ_d;
  result_t          res_q, res_d, out_q;
  logic             out_valid_q;
  logic             out_free, full, insert_mode, found;
  cell_ctrl_t       ctrl;
  entry_t           taken;

  entry_t           ents  [DEPTH];
  entry_t           sels  [DEPTH];
  logic [DEPTH:0]   chain;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (occ_q == OccW'(DEPTH));
  assign insert_mode   = (op_q == ACT_INSERT) || (op_q == ACT_APPEND);

  assign ctrl.match_en = (state_q == ST_MATCH);
  assign ctrl.apply_en = (state_q == ST_APPLY) && !(insert_mode && full);
  assign ctrl.op       = op_q;
  assign ctrl.key      = key_q;

  assign chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    prq_cell #(
      .IDX   (g),
      .OCC_W (OccW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .occ_i   (occ_q),
      .left_i  ((g == 0) ? key_q : ents[(g == 0) ? 0 : g - 1]),
      .right_i (ents[(g == DEPTH - 1) ? g : g + 1]),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .entry_o (ents[g]),
      .sel_o   (sels[g])
    );
  end

  // Only the first-hit cell drives a nonzero entry.
  always_comb begin
    taken = '0;
    for (int i = 0; i < DEPTH; i++) begin
      taken = taken | sels[i];
    end
  end

  assign found = !insert_mode && chain[DEPTH];

  always_comb begin
    occ_d = occ_q;
    if (state_q == ST_APPLY) begin
      if (insert_mode && !full) begin
        occ_d = occ_q + 1'b1;
      end else if (found) begin
        occ_d = occ_q - 1'b1;
      end
    end
  end

  always_comb begin
    res_d.found        = found;
    res_d.out_pid      = found ? taken.pid : '0;
    res_d.out_priority = found ? taken.prio : '0;
    res_d.empty_res    = (occ_d == '0);
    res_d.dropped      = insert_mode && full;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_APPLY;
      ST_APPLY: state_d = out_free ? ST_IDLE : ST_WAIT;
      ST_WAIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if ((state_q == ST_APPLY || state_q == ST_WAIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= action_e'(s_axis_tdata[1:0]);
      key_q.pid  <= s_axis_tdata[11:2];
      key_q.prio <= s_axis_tdata[19:12];
    end
    if (state_q == ST_APPLY) begin
      res_q <= res_d;
      if (out_free) begin
        out_q <= res_d;
      end
    end else if (state_q == ST_WAIT && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutW - $bits(result_t)){1'b0}}, out_q};

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OccW'(DEPTH))
    else $error("occupancy beyond capacity");

  // A refused insert never reports a removed entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20] |-> !m_axis_tdata[0])
    else $error("dropped and found together");

  // A result without a removed entry carries a zero entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[18:1] == '0)
    else $error("nonzero entry without a removal");

  // The sequencer handles one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while busy");

endmodule

@@ src/prq_cell.sv @@
module prq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned OCC_W = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prq_pkg::cell_ctrl_t ctrl_i,
  input  logic [OCC_W-1:0]    occ_i,
  input  prq_pkg::entry_t     left_i,
  input  prq_pkg::entry_t     right_i,
  input  logic                chain_i,
  output logic                chain_o,
  output prq_pkg::entry_t     entry_o,
  output prq_pkg::entry_t     sel_o
);
  import prq_pkg::*;

  entry_t entry_q, entry_d;
  logic   hit_q, hit_d;
  logic   occupied, tail, first, insert_mode;

  assign occupied    = OCC_W'(IDX) < occ_i;
  assign tail        = OCC_W'(IDX) == occ_i;
  assign insert_mode = (ctrl_i.op == ACT_INSERT) || (ctrl_i.op == ACT_APPEND);

  // Local compare, registered for the apply step.
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.match_en) begin
      unique case (ctrl_i.op)
        ACT_INSERT: hit_d = (occupied && (ctrl_i.key.prio < entry_q.prio)) || tail;
        ACT_APPEND: hit_d = tail;
        ACT_POP:    hit_d = (IDX == 0) && occupied;
        ACT_REMOVE: hit_d = occupied && (entry_q.pid == ctrl_i.key.pid);
        default:    hit_d = 1'b0;
      endcase
    end
  end

  // The chain marks every cell at or behind the first hit.
  assign chain_o = chain_i | hit_q;
  assign first   = hit_q & ~chain_i;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.apply_en) begin
      if (insert_mode) begin
        if (first) begin
          entry_d = ctrl_i.key;
        end else if (chain_i) begin
          entry_d = left_i;
        end
      end else if (chain_o) begin
        entry_d = right_i;
      end
    end
  end

  assign entry_o = entry_q;
  assign sel_o   = first ? entry_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ tb/tb_priority_ready_queue.sv @@
module tb_priority_ready_queue;
  import prq_pkg::*;

  // Queue depth used for the block and for the predictor.
  localparam int unsigned QDEPTH = 16;
  // The run is ended here if it has not finished on its own. The slowest correct
  // run needs roughly 1300 words, each with a sender gap, the work in the block
  // and a receiver stall, so this leaves plenty of margin.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_DIRECTED = 24;
  localparam int unsigned NUM_RANDOM = 1250;
  // From this random word on, neither side idles any more.
  localparam int unsigned QUIET_FROM = 1100;
  localparam int unsigned RANDOM_BLOCK = 125;

  // One result word, laid out as on m_axis_tdata from the top bit down.
  typedef struct packed {
    logic [2:0]       pad;
    logic             dropped;
    logic             empty_res;
    logic [PrioW-1:0] out_prio;
    logic [PidW-1:0]  out_pid;
    logic             found;
  } queue_result_t;

  // One row of the directed stimulus. When has_want is set, the result is given
  // in the row itself; otherwise the predictor supplies it.
  typedef struct packed {
    action_e          op;
    logic [PidW-1:0]  pid;
    logic [PrioW-1:0] prio;
    logic             has_want;
    queue_result_t    want;
  } stim_row_t;

  // A successful insert or append, and a remove that finds nothing in a
  // non-empty queue, both give an all-zero result word.
  localparam queue_result_t RES_NONE = '0;
  // Pop or remove on an empty queue finds nothing and reports empty.
  localparam queue_result_t RES_MISS_EMPTY = '{pad: 3'd0, dropped: 1'b0, empty_res: 1'b1,
                                               out_prio: '0, out_pid: '0, found: 1'b0};
  // Insert or append into a full queue is refused.
  localparam queue_result_t RES_DROP_FULL = '{pad: 3'd0, dropped: 1'b1, empty_res: 1'b0,
                                              out_prio: '0, out_pid: '0, found: 1'b0};

  // Directed part. It opens with misses on the empty queue. It then fills all
  // sixteen slots with extreme ids and priorities, ties, and appends that leave
  // the queue out of order. It tries both kinds of add on the full queue. It
  // ends with a remove that misses, a remove of a duplicated id (the front copy
  // must go), a pop, and a refill.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ACT_POP,    10'd0,    8'd0,   1'b1, RES_MISS_EMPTY},
    '{ACT_REMOVE, 10'd1023, 8'd255, 1'b1, RES_MISS_EMPTY},
    '{ACT_INSERT, 10'd1023, 8'd255, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd0,    8'd0,   1'b1, RES_NONE},
    '{ACT_INSERT, 10'd512,  8'd128, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd513,  8'd128, 1'b1, RES_NONE},
    '{ACT_APPEND, 10'd7,    8'd0,   1'b1, RES_NONE},
    '{ACT_INSERT, 10'd341,  8'd170, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd682,  8'd85,  1'b1, RES_NONE},
    '{ACT_APPEND, 10'd512,  8'd255, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd100,  8'd254, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd101,  8'd1,   1'b1, RES_NONE},
    '{ACT_INSERT, 10'd102,  8'd128, 1'b1, RES_NONE},
    '{ACT_APPEND, 10'd103,  8'd128, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd104,  8'd0,   1'b1, RES_NONE},
    '{ACT_INSERT, 10'd105,  8'd200, 1'b1, RES_NONE},
    '{ACT_INSERT, 10'd106,  8'd255, 1'b1, RES_NONE},
    '{ACT_APPEND, 10'd107,  8'd3,   1'b1, RES_NONE},
    '{ACT_INSERT, 10'd200,  8'd0,   1'b1, RES_DROP_FULL},
    '{ACT_APPEND, 10'd201,  8'd255, 1'b1, RES_DROP_FULL},
    '{ACT_REMOVE, 10'd999,  8'd0,   1'b1, RES_NONE},
    '{ACT_REMOVE, 10'd512,  8'd0,   1'b0, RES_NONE},
    '{ACT_POP,    10'd0,    8'd0,   1'b0, RES_NONE},
    '{ACT_INSERT, 10'd0,    8'd0,   1'b1, RES_NONE}
  };

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b1;
  logic [OutW-1:0] m_axis_tdata;

  // Predictor state: the entries in queue order, front at index 0.
  logic [PidW-1:0]  model_pid [QDEPTH];
  logic [PrioW-1:0] model_prio [QDEPTH];
  int unsigned      model_count = 0;
  int unsigned      peak_count = 0;

  // Results predicted for accepted words and not yet seen on m_axis.
  queue_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned empties_seen = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  priority_ready_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Safety net against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("[priority_ready_queue] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s is %0d, expected %0d", results_checked, what, got, want);
    mismatch_count++;
  endtask

  // Takes the entry at position pos out of the predicted queue and closes the
  // gap behind it.
  function automatic queue_result_t take_entry(int unsigned pos);
    queue_result_t r;
    r = '0;
    r.found = 1'b1;
    r.out_pid = model_pid[pos];
    r.out_prio = model_prio[pos];
    for (int unsigned i = pos; i + 1 < model_count; i++) begin
      model_pid[i] = model_pid[i + 1];
      model_prio[i] = model_prio[i + 1];
    end
    model_count--;
    return r;
  endfunction

  // Applies one operation to the predicted queue and returns the result word
  // that the block must produce for it.
  function automatic queue_result_t apply_queue_op(action_e op, logic [PidW-1:0] pid,
                                                   logic [PrioW-1:0] prio);
    queue_result_t r;
    int unsigned   pos;
    bit            hit;
    r = '0;
    pos = model_count;
    hit = 1'b0;
    case (op)
      ACT_INSERT, ACT_APPEND: begin
        if (model_count >= QDEPTH) begin
          r.dropped = 1'b1;
        end else begin
          // An insert stops at the first entry with a strictly greater
          // priority, scanning the entries as they lie, so ties keep their
          // arrival order and appended entries are not re-sorted.
          if (op == ACT_INSERT) begin
            for (int unsigned i = 0; i < model_count; i++) begin
              if (!hit && prio < model_prio[i]) begin
                pos = i;
                hit = 1'b1;
              end
            end
          end
          for (int unsigned i = model_count; i > pos; i--) begin
            model_pid[i] = model_pid[i - 1];
            model_prio[i] = model_prio[i - 1];
          end
          model_pid[pos] = pid;
          model_prio[pos] = prio;
          model_count++;
        end
      end
      ACT_POP: begin
        if (model_count > 0) r = take_entry(0);
      end
      default: begin
        // Remove by id takes only the first matching entry from the front.
        for (int unsigned i = 0; i < model_count; i++) begin
          if (!hit && model_pid[i] == pid) begin
            pos = i;
            hit = 1'b1;
          end
        end
        if (hit) r = take_entry(pos);
      end
    endcase
    r.empty_res = (model_count == 0);
    if (model_count > peak_count) peak_count = model_count;
    return r;
  endfunction

  // Offers one word on s_axis, optionally after a random idle burst, and waits
  // for it to be taken. On acceptance the predictor is advanced; the stored
  // expectation is the typed-in one when given, else the predicted one.
  task automatic send_op(input action_e op, input logic [PidW-1:0] pid,
                         input logic [PrioW-1:0] prio, input logic has_want,
                         input queue_result_t want);
    queue_result_t predicted;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, prio, pid, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_queue_op(op, pid, prio);
    pending_results.push_back(has_want ? want : predicted);
    words_sent++;
  endtask

  // Picks an operation; the mix depends on whether this block of the random
  // part should fill the queue, drain it, or keep it around the middle.
  function automatic action_e pick_action(int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: return roll < 50 ? ACT_INSERT : roll < 75 ? ACT_APPEND :
                roll < 85 ? ACT_POP : ACT_REMOVE;
      1: return roll < 15 ? ACT_INSERT : roll < 20 ? ACT_APPEND :
                roll < 60 ? ACT_POP : ACT_REMOVE;
      default: return roll < 30 ? ACT_INSERT : roll < 45 ? ACT_APPEND :
                      roll < 70 ? ACT_POP : ACT_REMOVE;
    endcase
  endfunction

  // Picks an id. Most ids come from a small pool, so duplicates are common.
  // A remove usually names an id that is currently stored. The rest spans the
  // whole field.
  function automatic logic [PidW-1:0] pick_pid(action_e op);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (model_count > 0 && (op == ACT_REMOVE ? roll < 70 : roll < 20))
      return model_pid[$urandom_range(0, model_count - 1)];
    if (roll < 85) return PidW'($urandom_range(0, 31));
    return PidW'($urandom_range(0, 1023));
  endfunction

  // Priorities cluster in a narrow band to force ties, with the extremes
  // and the full range mixed in.
  function automatic logic [PrioW-1:0] pick_prio();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return PrioW'($urandom_range(0, 7));
    if (roll == 4) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return PrioW'($urandom_range(0, 255));
  endfunction

  // Receiver: tready drops in random bursts between stretches of
  // varying length, some of them long, until the quiet tail of the run.
  initial begin
    int unsigned high_len;
    wait (rst_ni);
    while (!no_idle) begin
      high_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (high_len) @(posedge clk_i);
      if (!no_idle) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Checker: every word taken on m_axis is compared field by field with the
  // oldest pending expectation.
  always @(posedge clk_i) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", int'(got.found), int'(want.found));
        if (got.out_pid !== want.out_pid)
          report_mismatch("out_pid", int'(got.out_pid), int'(want.out_pid));
        if (got.out_prio !== want.out_prio)
          report_mismatch("out_priority", int'(got.out_prio), int'(want.out_prio));
        if (got.empty_res !== want.empty_res)
          report_mismatch("empty_res", int'(got.empty_res), int'(want.empty_res));
        if (got.dropped !== want.dropped)
          report_mismatch("dropped", int'(got.dropped), int'(want.dropped));
        if (got.pad !== want.pad)
          report_mismatch("padding bits", int'(got.pad), int'(want.pad));
        if (want.found) hits_seen++;
        if (want.dropped) drops_seen++;
        if (want.empty_res) empties_seen++;
      end
    end
  end

  // Sender: the directed rows first, then random blocks that take turns at
  // filling, draining and balancing the queue, then a tail with no idling.
  initial begin
    action_e op;
    wait (rst_ni);
    @(posedge clk_i);
    for (int unsigned n = 0; n < NUM_DIRECTED; n++) begin
      send_op(directed_rows[n].op, directed_rows[n].pid, directed_rows[n].prio,
              directed_rows[n].has_want, directed_rows[n].want);
    end
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      if (n == QUIET_FROM) no_idle = 1'b1;
      op = pick_action((n / RANDOM_BLOCK) % 3);
      send_op(op, pick_pid(op), pick_prio(), 1'b0, RES_NONE);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Wait on afterwards so a stray extra result would be caught.
    repeat (10) @(posedge clk_i);
    $display("sent %0d operation words, checked %0d results in %0d cycles",
             words_sent, results_checked, cycle_count);
    $display("entries taken out: %0d, adds refused when full: %0d,",
             hits_seen, drops_seen);
    $display("empty reports: %0d, peak fill %0d", empties_seen, peak_count);
    if (mismatch_count == 0) begin
      $display("[priority_ready_queue] OK");
    end else begin
      $display("[priority_ready_queue] ERROR");
    end
    $finish;
  end

endmodule
